// File: rtl/qmn_pkg.sv
package qmn_pkg;

    localparam int COMP_W            = 16;
    localparam int FRAC_BITS_DEFAULT = 14;

    typedef struct packed {
        logic signed [COMP_W-1:0] a_w;
        logic signed [COMP_W-1:0] a_x;
        logic signed [COMP_W-1:0] a_y;
        logic signed [COMP_W-1:0] a_z;
        logic signed [COMP_W-1:0] b_w;
        logic signed [COMP_W-1:0] b_x;
        logic signed [COMP_W-1:0] b_y;
        logic signed [COMP_W-1:0] b_z;
    } operands_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] r_w;
        logic signed [COMP_W-1:0] r_x;
        logic signed [COMP_W-1:0] r_y;
        logic signed [COMP_W-1:0] r_z;
        logic                     degenerate;
    } result_t;

endpackage

// File: rtl/quaternion_multiply_normalize.sv
// Normalised Hamilton product of two Q2.FRAC_BITS quaternions.
//
// Input: drive operands and raise start; the transfer happens on any edge
// with start high and busy low. busy is always low, so one operand pair can
// be taken every clock cycle.
// Output: done is high for exactly one cycle with result valid alongside;
// the receiver must take it then, it cannot hold results off.
// Pipeline: the rounding search produces one result bit per pipeline stage
// across FRAC_BITS + 1 stages, behind six stages of product, magnitude,
// square and sum; throughput is one result per cycle.
// A zero-length product yields the identity (1,0,0,0) with degenerate set.
// Reset (rst_n low, asynchronous) clears all valid bits, so everything in
// flight is dropped; payload registers are not reset.
module quaternion_multiply_normalize
    import qmn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  operands_t operands,
    output logic      done,
    output result_t   result
);

    localparam int PW  = 2 * COMP_W + 2;       // Hamilton component
    localparam int MGW = PW - 1;               // its magnitude
    localparam int SQW = 2 * MGW;              // magnitude squared, sum of squares
    localparam int GW  = 2 * FRAC_BITS + SQW + 6;
    localparam int NS  = FRAC_BITS + 1;        // result bits
    localparam int OW  = (NS + 1 > COMP_W) ? NS + 1 : COMP_W;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    logic signed [COMP_W-1:0] av [0:3];
    logic signed [COMP_W-1:0] bv [0:3];
    assign av[0] = operands.a_w;
    assign av[1] = operands.a_x;
    assign av[2] = operands.a_y;
    assign av[3] = operands.a_z;
    assign bv[0] = operands.b_w;
    assign bv[1] = operands.b_x;
    assign bv[2] = operands.b_y;
    assign bv[3] = operands.b_z;

    // front valid chain: products, sums, magnitudes, squares, sum of squares
    logic [4:0] fv_reg;

    logic signed [2*COMP_W-1:0] prod_reg [0:3][0:3];
    logic signed [PW-1:0]       p_reg    [0:3];
    logic [MGW-1:0]             mag_reg  [0:3];
    logic [3:0]                 neg3_reg;
    logic [SQW-1:0]             sq_reg   [0:3];
    logic [3:0]                 neg4_reg;
    logic [SQW-1:0]             sq5_reg  [0:3];
    logic [SQW-1:0]             ss5_reg;
    logic [3:0]                 neg5_reg;

    // search pipeline, index 0 is the initial state
    logic signed [GW-1:0] g_reg   [0:NS][0:3];
    logic signed [GW-1:0] w_reg   [0:NS][0:3];
    logic [NS-1:0]        m_reg   [0:NS][0:3];
    logic [SQW-1:0]       ss_reg  [0:NS];
    logic [3:0]           neg_reg [0:NS];
    logic                 deg_reg [0:NS];
    logic [NS:0]          sv_reg;

    result_t result_reg;
    logic    done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg   <= '0;
            sv_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fv_reg   <= {fv_reg[3:0], accept};
            sv_reg   <= {sv_reg[NS-1:0], fv_reg[4]};
            done_reg <= sv_reg[NS];
        end
    end

    logic signed [PW-1:0] pe [0:3][0:3];
    logic signed [PW-1:0] p_next [0:3];
    logic [SQW-1:0]       ss_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                pe[i][j] = PW'(prod_reg[i][j]);
        p_next[0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
        p_next[1] = pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
        p_next[2] = pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1];
        p_next[3] = pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0];
        ss_next   = sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
                prod_reg[i][j] <= av[i] * bv[j];
            p_reg[i]   <= p_next[i];
            mag_reg[i] <= p_reg[i][PW-1] ? MGW'(-p_reg[i]) : MGW'(p_reg[i]);
            neg3_reg[i] <= p_reg[i][PW-1];
            sq_reg[i]  <= SQW'(mag_reg[i]) * SQW'(mag_reg[i]);
            sq5_reg[i] <= sq_reg[i];
        end
        neg4_reg <= neg3_reg;
        neg5_reg <= neg4_reg;
        ss5_reg  <= ss_next;
    end

    // initial residual: mag^2 * 4^(F+1) - ss, i.e. trial value m = 0
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            g_reg[0][i] <= ($signed(GW'(sq5_reg[i])) <<< (2 * FRAC_BITS + 2))
                           - $signed(GW'(ss5_reg));
            w_reg[0][i] <= '0;
            m_reg[0][i] <= '0;
        end
        ss_reg[0]  <= ss5_reg;
        neg_reg[0] <= neg5_reg;
        deg_reg[0] <= (ss5_reg == '0);
    end

    // Largest m with (2m-1)^2 * ss <= mag^2 * 4^(F+1), one bit per stage.
    // g holds that bound minus (u-1)^2 * ss, w holds u * ss, with u = 2m.
    for (genvar j = 0; j < NS; j++)
    begin : g_stage
        localparam int K = FRAC_BITS - j;
        logic signed [GW-1:0] ssx;
        logic signed [GW-1:0] cand [0:3];

        assign ssx = $signed(GW'(ss_reg[j]));

        always_comb
        begin
            for (int i = 0; i < 4; i++)
                cand[i] = g_reg[j][i] - (w_reg[j][i] <<< (K + 2))
                          - (ssx <<< (2 * K + 2)) + (ssx <<< (K + 2));
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (!cand[i][GW-1])
                begin
                    g_reg[j+1][i] <= cand[i];
                    w_reg[j+1][i] <= w_reg[j][i] + (ssx <<< (K + 1));
                    m_reg[j+1][i] <= m_reg[j][i] | (NS'(1) << K);
                end
                else
                begin
                    g_reg[j+1][i] <= g_reg[j][i];
                    w_reg[j+1][i] <= w_reg[j][i];
                    m_reg[j+1][i] <= m_reg[j][i];
                end
            end
            ss_reg[j+1]  <= ss_reg[j];
            neg_reg[j+1] <= neg_reg[j];
            deg_reg[j+1] <= deg_reg[j];
        end
    end

    logic signed [OW-1:0] r_ext [0:3];
    logic [OW-1:0]        one_ext;

    always_comb
    begin
        one_ext = OW'(1) << FRAC_BITS;
        for (int i = 0; i < 4; i++)
        begin
            r_ext[i] = $signed(OW'(m_reg[NS][i]));
            if (neg_reg[NS][i])
                r_ext[i] = -r_ext[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (deg_reg[NS])
        begin
            result_reg.r_w <= one_ext[COMP_W-1:0];
            result_reg.r_x <= '0;
            result_reg.r_y <= '0;
            result_reg.r_z <= '0;
        end
        else
        begin
            result_reg.r_w <= r_ext[0][COMP_W-1:0];
            result_reg.r_x <= r_ext[1][COMP_W-1:0];
            result_reg.r_y <= r_ext[2][COMP_W-1:0];
            result_reg.r_z <= r_ext[3][COMP_W-1:0];
        end
        result_reg.degenerate <= deg_reg[NS];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: tb/quaternion_multiply_normalize_tb.sv
`timescale 1ns / 100ps

module quaternion_multiply_normalize_tb;
    import qmn_pkg::*;

    localparam int FB = FRAC_BITS_DEFAULT;
    localparam int LATENCY = FB + 8;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    operands_t operands;
    logic      done;
    result_t   result;

    operands_t pending_ops[$];
    result_t   expected_results[$];
    int        mismatches;
    int        checked;
    int        degenerate_seen;
    int        gap;
    logic      busy_sampled;

    quaternion_multiply_normalize #(.FRAC_BITS(FB)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operands(operands),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // round(2^FB * mag / sqrt(ss)) by search on the largest k with
    // (2k-1)^2 * ss <= 4 * mag^2 * 2^(2FB); ties go away from zero
    function automatic logic [15:0] norm_component(longint signed p, logic [127:0] ss);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [63:0]  mag;
        longint       lo;
        longint       hi;
        longint       mid;
        lo  = 0;
        hi  = longint'(1) << FB;
        mag = (p < 0) ? -p : p;
        rhs = (128'(mag) * 128'(mag)) << (2 * FB + 2);
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = 128'(2 * mid - 1) * 128'(2 * mid - 1) * ss;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (p < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic result_t hamilton_unit(operands_t o);
        longint signed aw, ax, ay, az, bw, bx, by, bz;
        longint signed p[4];
        logic [63:0]   m;
        logic [127:0]  ss;
        result_t       r;
        aw = o.a_w; ax = o.a_x; ay = o.a_y; az = o.a_z;
        bw = o.b_w; bx = o.b_x; by = o.b_y; bz = o.b_z;
        p[0] = aw * bw - ax * bx - ay * by - az * bz;
        p[1] = aw * bx + ax * bw + ay * bz - az * by;
        p[2] = aw * by - ax * bz + ay * bw + az * bx;
        p[3] = aw * bz + ax * by - ay * bx + az * bw;
        ss = '0;
        // squares can pass 2^63, so square the magnitude unsigned
        for (int i = 0; i < 4; i++)
        begin
            m = (p[i] < 0) ? -p[i] : p[i];
            ss += 128'(m) * 128'(m);
        end
        if (ss == 0)
        begin
            r.r_w = 16'(longint'(1) << FB);
            r.r_x = '0;
            r.r_y = '0;
            r.r_z = '0;
            r.degenerate = 1'b1;
        end
        else
        begin
            r.r_w = norm_component(p[0], ss);
            r.r_x = norm_component(p[1], ss);
            r.r_y = norm_component(p[2], ss);
            r.r_z = norm_component(p[3], ss);
            r.degenerate = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(1 << FB);
            4: return 16'(-(1 << FB));
            5: return 16'($urandom_range(0, 7)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic operands_t random_ops();
        operands_t o;
        o = operands_t'({$urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(0, 5))
            0:
            begin
                o.a_w = pick_comp(); o.a_x = pick_comp();
                o.a_y = pick_comp(); o.a_z = pick_comp();
                o.b_w = pick_comp(); o.b_x = pick_comp();
                o.b_y = pick_comp(); o.b_z = pick_comp();
            end
            1:
            begin
                // one side zero gives a degenerate product
                if ($urandom_range(0, 1))
                    {o.a_w, o.a_x, o.a_y, o.a_z} = '0;
                else
                    {o.b_w, o.b_x, o.b_y, o.b_z} = '0;
            end
            2:
            begin
                o.a_w = 16'($signed(o.a_w) >>> 10); o.a_x = 16'($signed(o.a_x) >>> 12);
                o.b_y = 16'($signed(o.b_y) >>> 9);  o.b_z = 16'($signed(o.b_z) >>> 13);
            end
            default: ;
        endcase
        return o;
    endfunction

    // driver: one transfer per queued item, random gap between them
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            operands <= '0;
        end
        else if (start && !busy_sampled)
        begin
            void'(pending_ops.pop_front());
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (gap == 0 && pending_ops.size() > 0)
                operands <= pending_ops[0];
            else
                start <= 1'b0;
        end
        else if (!start && pending_ops.size() > 0)
        begin
            if (gap > 0)
                gap--;
            else
            begin
                operands <= pending_ops[0];
                start <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        busy_sampled <= busy;
        if (rst_n && start && !busy)
            expected_results.push_back(hamilton_unit(operands));
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                result_t want;
                want = expected_results.pop_front();
                checked++;
                if (want.degenerate)
                    degenerate_seen++;
                if (result.r_w !== want.r_w) report_mismatch("r_w", result.r_w, want.r_w);
                if (result.r_x !== want.r_x) report_mismatch("r_x", result.r_x, want.r_x);
                if (result.r_y !== want.r_y) report_mismatch("r_y", result.r_y, want.r_y);
                if (result.r_z !== want.r_z) report_mismatch("r_z", result.r_z, want.r_z);
                if (result.degenerate !== want.degenerate)
                    report_mismatch("degenerate", result.degenerate, want.degenerate);
            end
        end
    end

    initial
    begin
        #20ms;
        $display("timeout, %0d results still expected", expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [15:0] one;
        one = 16'(1 << FB);
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: identities, axes, zero, extremes, opposite sign
        pending_ops.push_back(operands_t'({one, 48'h0, one, 48'h0}));
        pending_ops.push_back(operands_t'({16'h0, one, 32'h0, 16'h0, one, 32'h0}));
        pending_ops.push_back(operands_t'({32'h0, one, 16'h0, 48'h0, one}));
        pending_ops.push_back(operands_t'({128'h0}));
        pending_ops.push_back(operands_t'({64'h0, {4{16'h7FFF}}}));
        pending_ops.push_back(operands_t'({{8{16'h8000}}}));
        pending_ops.push_back(operands_t'({{8{16'h7FFF}}}));
        pending_ops.push_back(operands_t'({{4{16'h8000}}, {4{16'h7FFF}}}));
        pending_ops.push_back(operands_t'({{4{16'hFFFF}}, {4{16'h0001}}}));
        pending_ops.push_back(operands_t'({16'h0001, 48'h0, 16'h0001, 48'h0}));
        pending_ops.push_back(operands_t'({16'h0001, 48'h0, 16'hFFFF, 48'h0}));
        pending_ops.push_back(operands_t'({16'h0003, 16'h0004, 32'h0, one, 48'h0}));
        pending_ops.push_back(operands_t'({16'h0001, 16'h0001, 32'h0, one, 48'h0}));
        pending_ops.push_back(operands_t'({16'h8000, 48'h0, 16'h8000, 48'h0}));
        pending_ops.push_back(operands_t'({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                           16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}));
        for (int i = 0; i < 1100; i++)
            pending_ops.push_back(random_ops());

        wait (pending_ops.size() == 0 && !start);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);

        $display("checked %0d normalised products, %0d of them zero-length",
                 checked, degenerate_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/qmn_pkg.sv
rtl/quaternion_multiply_normalize.sv
tb/quaternion_multiply_normalize_tb.sv
